@@ src/uyv_pkg.sv @@
// Shared types, constants and arithmetic helpers for the UYVY to BGR converter.
package uyv_pkg;

  localparam int UYV_QUEUE_DEPTH = 6;   // pixel descriptors buffered ahead of conversion
  localparam int UYV_BURST       = 4;   // most pixels one macropixel beat can release

  // fixed-point coefficients, 10 fractional bits
  localparam logic signed [12:0] K_Y       = 13'sd1192;
  localparam logic signed [20:0] Y_ROUND   = 21'sd512;
  localparam logic signed [9:0]  Y_OFFSET  = 10'sd16;
  localparam logic signed [8:0]  C_OFFSET  = 9'sd128;

  localparam logic signed [12:0] K709_U    = 13'sd2165;
  localparam logic signed [12:0] K709_UM   = -13'sd218;
  localparam logic signed [12:0] K709_V    = 13'sd1836;
  localparam logic signed [12:0] K709_VM   = -13'sd547;
  localparam logic signed [12:0] K601_U    = 13'sd2065;
  localparam logic signed [12:0] K601_UM   = -13'sd401;
  localparam logic signed [12:0] K601_V    = 13'sd1634;
  localparam logic signed [12:0] K601_VM   = -13'sd832;

  // one output pixel waiting for conversion
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       last;
  } pix_desc_t;

  // rounded mean of two chroma samples
  function automatic logic [7:0] chroma_avg(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + 9'd1;
    return s[8:1];
  endfunction

  // floor(x / 1024) clamped to 0..255
  function automatic logic [7:0] clamp_u8(input logic signed [21:0] x);
    logic [7:0] r;
    if (x[21]) begin
      r = 8'd0;
    end else if (x[20:18] != 3'd0) begin
      r = 8'd255;
    end else begin
      r = x[17:10];
    end
    return r;
  endfunction

endpackage

@@ src/uyv_pair.sv @@
// Macropixel holding, chroma pairing and the pixel descriptor queue.
module uyv_pair #(
  parameter int QUEUE_DEPTH = uyv_pkg::UYV_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               mp_valid,
  output logic               mp_ready,
  input  logic [7:0]         chroma_blue,
  input  logic [7:0]         luma_first,
  input  logic [7:0]         chroma_red,
  input  logic [7:0]         luma_second,
  input  logic               line_end,
  input  logic               pop,
  output logic               desc_valid,
  output uyv_pkg::pix_desc_t desc
);
  import uyv_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] READY_LIMIT = CNT_W'(QUEUE_DEPTH - UYV_BURST);

  logic [7:0]       held_u, held_y0, held_v, held_y1;
  logic             held_valid;
  logic [CNT_W-1:0] count, count_next, count_after_pop;
  pix_desc_t        queue [QUEUE_DEPTH];
  pix_desc_t        queue_next [QUEUE_DEPTH];
  pix_desc_t        burst [UYV_BURST];
  logic [2:0]       burst_len;
  logic             accept;
  logic [CNT_W-1:0] slot_ofs;

  assign mp_ready   = (count <= READY_LIMIT);
  assign accept     = mp_valid && mp_ready;
  assign desc_valid = (count != '0);
  assign desc       = queue[0];

  // pixels released by this beat, in display order
  always_comb begin
    pix_desc_t own0, own1, hold0, hold1;
    own0  = '{luma: luma_first,  cb: chroma_blue, cr: chroma_red, last: 1'b0};
    own1  = '{luma: luma_second, cb: chroma_blue, cr: chroma_red, last: 1'b1};
    hold0 = '{luma: held_y0, cb: held_u, cr: held_v, last: 1'b0};
    hold1 = '{luma: held_y1, cb: chroma_avg(held_u, chroma_blue),
              cr: chroma_avg(held_v, chroma_red), last: 1'b0};
    if (held_valid) begin
      burst[0] = hold0;
      burst[1] = hold1;
      burst[2] = own0;
      burst[3] = own1;
    end else begin
      burst[0] = own0;
      burst[1] = own1;
      burst[2] = own0;
      burst[3] = own1;
    end
    burst_len = {held_valid && line_end, held_valid ^ line_end, 1'b0};
  end

  // shift queue: pop from the head, append the burst behind what remains
  always_comb begin
    count_after_pop = count - CNT_W'(pop && desc_valid);
    slot_ofs        = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && desc_valid && (i < QUEUE_DEPTH - 1)) begin
        queue_next[i] = queue[i + 1];
      end else begin
        queue_next[i] = queue[i];
      end
      slot_ofs = CNT_W'(i) - count_after_pop;
      if (accept && (CNT_W'(i) >= count_after_pop) && (slot_ofs < CNT_W'(burst_len))) begin
        queue_next[i] = burst[slot_ofs[1:0]];
      end
    end
    count_next = count_after_pop + (accept ? CNT_W'(burst_len) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      held_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        held_valid <= !line_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue[i] <= queue_next[i];
    end
    if (accept) begin
      held_u  <= chroma_blue;
      held_y0 <= luma_first;
      held_v  <= chroma_red;
      held_y1 <= luma_second;
    end
  end

endmodule

@@ src/uyv_convert.sv @@
// Two-stage YCbCr to BGR conversion with the output register.
module uyv_convert (
  input  logic               clk,
  input  logic               rst,
  input  logic               use_bt601,
  input  logic               desc_valid,
  input  uyv_pkg::pix_desc_t desc,
  output logic               pop,
  output logic               pixel_valid,
  input  logic               pixel_ready,
  output logic [7:0]         blue,
  output logic [7:0]         green,
  output logic [7:0]         red,
  output logic               last_of_line
);
  import uyv_pkg::*;

  logic                advance;
  logic                prod_valid;
  logic signed [20:0]  y_term, b_u, g_u, g_v, r_v;
  logic                prod_last;
  logic signed [12:0]  ku, kum, kv, kvm;
  logic signed [9:0]  y_c;
  logic signed [8:0]  u_c, v_c;

  // whole pipeline moves unless the output register is full and stalled
  assign advance = !pixel_valid || pixel_ready;
  assign pop     = advance;

  always_comb begin
    if (use_bt601) begin
      ku = K601_U; kum = K601_UM; kv = K601_V; kvm = K601_VM;
    end else begin
      ku = K709_U; kum = K709_UM; kv = K709_V; kvm = K709_VM;
    end
    y_c = $signed({2'b00, desc.luma}) - Y_OFFSET;
    u_c = $signed({1'b0, desc.cb}) - C_OFFSET;
    v_c = $signed({1'b0, desc.cr}) - C_OFFSET;
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (advance) begin
      y_term    <= 21'(y_c) * 21'(K_Y) + Y_ROUND;
      b_u       <= 21'(u_c) * 21'(ku);
      g_u       <= 21'(u_c) * 21'(kum);
      g_v       <= 21'(v_c) * 21'(kvm);
      r_v       <= 21'(v_c) * 21'(kv);
      prod_last <= desc.last;
    end
  end

  // stage 2: sums, clamp, output register
  always_ff @(posedge clk) begin
    if (advance) begin
      blue         <= clamp_u8(22'(y_term) + 22'(b_u));
      green        <= clamp_u8(22'(y_term) + 22'(g_v) + 22'(g_u));
      red          <= clamp_u8(22'(y_term) + 22'(r_v));
      last_of_line <= prod_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid  <= 1'b0;
      pixel_valid <= 1'b0;
    end else if (advance) begin
      prod_valid  <= desc_valid;
      pixel_valid <= prod_valid;
    end
  end

endmodule

@@ src/uyvy_to_bgr_pixel_converter_top.sv @@
// Top level of the UYVY macropixel to BGR pixel converter.
// Path: a released macropixel's pixels pass the pixel queue, the product stage and the
//   output register, one per cycle while pixel_ready is high; the releasing beat is the
//   next macropixel of the line or its own line_end beat. Macropixels go at half the
//   pixel rate, and a 6-entry pixel queue absorbs line-end bursts.
// Reset (rst, synchronous): empties queue and pipeline, drops the held macropixel, BT.709.
module uyvy_to_bgr_pixel_converter_top #(
  parameter int QUEUE_DEPTH = uyv_pkg::UYV_QUEUE_DEPTH  // at least 4
) (
  input  logic       clk,
  input  logic       rst,
  // configuration: BT.601 select
  input  logic       cfg_write_en,
  input  logic       cfg_write_data,
  // macropixel beats
  input  logic       macropixel_valid,
  output logic       macropixel_ready,
  input  logic [7:0] chroma_blue,
  input  logic [7:0] luma_first,
  input  logic [7:0] chroma_red,
  input  logic [7:0] luma_second,
  input  logic       line_end,
  // pixel beats
  output logic       pixel_valid,
  input  logic       pixel_ready,
  output logic [7:0] blue,
  output logic [7:0] green,
  output logic [7:0] red,
  output logic       last_of_line
);
  import uyv_pkg::*;

  logic      use_bt601;
  logic      desc_valid;
  logic      pop;
  pix_desc_t desc;

  // coefficient select; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      use_bt601 <= 1'b0;
    end else if (cfg_write_en) begin
      use_bt601 <= cfg_write_data;
    end
  end

  // holds one macropixel back so its second pixel can average chroma with the next one
  uyv_pair #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_pair (
    .clk        (clk),
    .rst        (rst),
    .mp_valid   (macropixel_valid),
    .mp_ready   (macropixel_ready),
    .chroma_blue(chroma_blue),
    .luma_first (luma_first),
    .chroma_red (chroma_red),
    .luma_second(luma_second),
    .line_end   (line_end),
    .pop        (pop),
    .desc_valid (desc_valid),
    .desc       (desc)
  );

  // products, then sums and clamp into the output register
  uyv_convert u_convert (
    .clk         (clk),
    .rst         (rst),
    .use_bt601   (use_bt601),
    .desc_valid  (desc_valid),
    .desc        (desc),
    .pop         (pop),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .last_of_line(last_of_line)
  );

endmodule

@@ src/uyv_checker.sv @@
// Port-level checks for the converter top, attached by bind.
module uyv_checker (
  input logic clk,
  input logic rst,
  input logic macropixel_ready,
  input logic pixel_valid,
  input logic pixel_ready,
  input logic last_of_line,
  input logic [7:0] blue,
  input logic [7:0] green,
  input logic [7:0] red
);

  // a stalled pixel keeps its value
  a_pixel_hold: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_ready) |=>
      (pixel_valid && $stable(blue) && $stable(green) && $stable(red) && $stable(last_of_line)))
    else $error("stalled pixel beat changed");

  // two accepted line-ending pixels never come back to back
  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && pixel_ready && last_of_line) |=>
      !(pixel_valid && pixel_ready && last_of_line))
    else $error("two line-ending pixels back to back");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !pixel_valid)
    else $error("pixel valid after reset");

  // reset empties the queue, so input is taken right away
  a_reset_ready: assert property (@(posedge clk) rst |=> macropixel_ready)
    else $error("not ready after reset");

endmodule

bind uyvy_to_bgr_pixel_converter_top uyv_checker u_uyv_checker (
  .clk             (clk),
  .rst             (rst),
  .macropixel_ready(macropixel_ready),
  .pixel_valid     (pixel_valid),
  .pixel_ready     (pixel_ready),
  .last_of_line    (last_of_line),
  .blue            (blue),
  .green           (green),
  .red             (red)
);

@@ tb/sv/bgr_pixel_checker.sv @@
`timescale 1ns / 100ps
// Checker: predicts BGR pixels from accepted macropixel beats and compares pixel beats.
module bgr_pixel_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic       cfg_write_data,
  input  logic       macropixel_valid,
  input  logic       macropixel_ready,
  input  logic [7:0] chroma_blue,
  input  logic [7:0] luma_first,
  input  logic [7:0] chroma_red,
  input  logic [7:0] luma_second,
  input  logic       line_end,
  input  logic       pixel_valid,
  input  logic       pixel_ready,
  input  logic [7:0] blue,
  input  logic [7:0] green,
  input  logic [7:0] red,
  input  logic       last_of_line,
  output int         mismatches,
  output int         pending
);

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic       last;
  } bgr_pixel_t;

  bgr_pixel_t expected_pixels[$];

  logic       sd_coeffs = 1'b0;
  logic       held_ok   = 1'b0;
  logic [7:0] held_u, held_y0, held_v, held_y1;
  int         err_count = 0;

  // floor(acc / 1024), saturated to a byte
  function automatic logic [7:0] saturate(input int acc);
    int q;
    q = acc >>> 10;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  function automatic logic [7:0] chroma_mean(input logic [7:0] a, input logic [7:0] c);
    int s;
    s = (int'(a) + int'(c) + 1) >> 1;
    return s[7:0];
  endfunction

  function automatic bgr_pixel_t ycbcr_to_bgr(input logic [7:0] y_s, input logic [7:0] u_s,
                                              input logic [7:0] v_s, input logic sd,
                                              input logic last);
    int ku, kum, kv, kvm, yt, ut, vt;
    bgr_pixel_t px;
    if (sd) begin
      ku = 2065; kum = -401; kv = 1634; kvm = -832;
    end else begin
      ku = 2165; kum = -218; kv = 1836; kvm = -547;
    end
    yt = 1192 * (int'(y_s) - 16) + 512;
    ut = int'(u_s) - 128;
    vt = int'(v_s) - 128;
    px.b    = saturate(yt + ku * ut);
    px.g    = saturate(yt + kvm * vt + kum * ut);
    px.r    = saturate(yt + kv * vt);
    px.last = last;
    return px;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    bgr_pixel_t want;
    if (rst) begin
      expected_pixels.delete();
      sd_coeffs = 1'b0;
      held_ok   = 1'b0;
      held_u    = 8'd0;
      held_y0   = 8'd0;
      held_v    = 8'd0;
      held_y1   = 8'd0;
    end else begin
      if (cfg_write_en) sd_coeffs = cfg_write_data;

      if (macropixel_valid && macropixel_ready) begin
        // a new beat releases the held macropixel, second pixel on averaged chroma
        if (held_ok) begin
          expected_pixels.push_back(ycbcr_to_bgr(held_y0, held_u, held_v, sd_coeffs, 1'b0));
          expected_pixels.push_back(ycbcr_to_bgr(held_y1, chroma_mean(held_u, chroma_blue),
                                                 chroma_mean(held_v, chroma_red),
                                                 sd_coeffs, 1'b0));
        end
        if (line_end) begin
          expected_pixels.push_back(ycbcr_to_bgr(luma_first, chroma_blue, chroma_red,
                                                 sd_coeffs, 1'b0));
          expected_pixels.push_back(ycbcr_to_bgr(luma_second, chroma_blue, chroma_red,
                                                 sd_coeffs, 1'b1));
          held_ok = 1'b0;
        end else begin
          held_u  = chroma_blue;
          held_y0 = luma_first;
          held_v  = chroma_red;
          held_y1 = luma_second;
          held_ok = 1'b1;
        end
      end

      if (pixel_valid && pixel_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: pixel with none expected, actual b=%0d g=%0d r=%0d last=%0b",
                   $time, blue, green, red, last_of_line);
          err_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("blue", want.b, blue);
          check_field("green", want.g, green);
          check_field("red", want.r, red);
          check_field("last_of_line", {7'd0, want.last}, {7'd0, last_of_line});
        end
      end
    end
    mismatches <= err_count;
    pending    <= expected_pixels.size();
  end

endmodule

@@ tb/sv/uyvy_to_bgr_pixel_converter_top_test.sv @@
`timescale 1ns / 100ps
// Testbench top: stimulus, pixel back-pressure, watchdog and verdict for the converter.
module uyvy_to_bgr_pixel_converter_top_test;

  // a run with no beat on either side for this many cycles is hung
  localparam int STALL_LIMIT = 2000;
  // idle cycles after the last pixel before touching the register
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 8;
  localparam int BEATS_PER_PHASE = 25;

  // receiver back-pressure styles
  typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_CHOKE} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write_en = 1'b0;
  logic       cfg_write_data = 1'b0;
  logic       macropixel_valid = 1'b0;
  logic       macropixel_ready;
  logic [7:0] chroma_blue = 8'd0;
  logic [7:0] luma_first = 8'd0;
  logic [7:0] chroma_red = 8'd0;
  logic [7:0] luma_second = 8'd0;
  logic       line_end = 1'b0;
  logic       pixel_valid;
  logic       pixel_ready = 1'b0;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       last_of_line;

  int mismatches;
  int pending;

  uyvy_to_bgr_pixel_converter_top u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .macropixel_valid (macropixel_valid),
    .macropixel_ready (macropixel_ready),
    .chroma_blue      (chroma_blue),
    .luma_first       (luma_first),
    .chroma_red       (chroma_red),
    .luma_second      (luma_second),
    .line_end         (line_end),
    .pixel_valid      (pixel_valid),
    .pixel_ready      (pixel_ready),
    .blue             (blue),
    .green            (green),
    .red              (red),
    .last_of_line     (last_of_line)
  );

  bgr_pixel_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .macropixel_valid (macropixel_valid),
    .macropixel_ready (macropixel_ready),
    .chroma_blue      (chroma_blue),
    .luma_first       (luma_first),
    .chroma_red       (chroma_red),
    .luma_second      (luma_second),
    .line_end         (line_end),
    .pixel_valid      (pixel_valid),
    .pixel_ready      (pixel_ready),
    .blue             (blue),
    .green            (green),
    .red              (red),
    .last_of_line     (last_of_line),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pixel side back-pressure. The style is redrawn periodically so stalls land
  // on every point of the release pattern: wide open, coin flip, a fixed comb,
  // and rare long chokes that let the pixel queue fill up behind line ends.
  // ---------------------------------------------------------------------------
  int       rx_tick = 0;
  int       rx_hold = 0;
  rx_mode_t rx_mode = RX_OPEN;

  always @(posedge clk) begin
    rx_tick = rx_tick + 1;
    if (rx_tick % 97 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      pixel_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: pixel_ready <= 1'b1;
        RX_COIN: pixel_ready <= 1'($urandom_range(0, 1));
        RX_COMB: pixel_ready <= (rx_tick % 5) != 0;
        default: begin
          if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(4, 20);
          pixel_ready <= 1'b1;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: counts cycles with no beat on either channel.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (macropixel_valid && macropixel_ready) || (pixel_valid && pixel_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL uyvy_to_bgr_pixel_converter_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Macropixel side. Beats go out in bursts; between bursts valid drops for a
  // random gap and the payload carries junk that must be ignored. "steady"
  // turns the gaps off for a back-to-back stretch.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  bit steady = 1'b0;

  task automatic send_macropixel(input logic [7:0] u, input logic [7:0] y0,
                                 input logic [7:0] v, input logic [7:0] y1,
                                 input logic le);
    int gap;
    macropixel_valid <= 1'b1;
    chroma_blue      <= u;
    luma_first       <= y0;
    chroma_red       <= v;
    luma_second      <= y1;
    line_end         <= le;
    @(posedge clk);
    while (!macropixel_ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        macropixel_valid <= 1'b0;
        chroma_blue      <= 8'($urandom);
        luma_first       <= 8'($urandom);
        chroma_red       <= 8'($urandom);
        luma_second      <= 8'($urandom);
        line_end         <= 1'($urandom);
        @(posedge clk);
      end
    end
  endtask

  // Sender holds off until every predicted pixel is out, then lets the
  // pipeline go quiet. Phases always end on a line end, so nothing is held.
  task automatic settle_block();
    macropixel_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_standard(input logic sd);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= sd;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // mostly uniform, sometimes a clamp or offset corner
  function automatic logic [7:0] pick_sample();
    logic [7:0] s;
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 5))
        0:       s = 8'd0;
        1:       s = 8'd255;
        2:       s = 8'd16;
        3:       s = 8'd235;
        4:       s = 8'd127;
        default: s = 8'd128;
      endcase
    end else begin
      s = 8'($urandom_range(0, 255));
    end
    return s;
  endfunction

  // Corners: one-macropixel lines at both extremes and neutral gray, a line
  // whose chroma swings rail to rail (average rounding), a line end that
  // flushes a held macropixel (four pixels at once), and alternating bit
  // patterns so every payload bit toggles.
  task automatic run_corners();
    send_macropixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
    send_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_macropixel(8'd128, 8'd16,  8'd128, 8'd235, 1'b1);
    send_macropixel(8'd0,   8'd16,  8'd255, 8'd235, 1'b0);
    send_macropixel(8'd255, 8'd235, 8'd0,   8'd16,  1'b0);
    send_macropixel(8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
    send_macropixel(8'd127, 8'd81,  8'd129, 8'd90,  1'b1);
    send_macropixel(8'd255, 8'd255, 8'd0,   8'd0,   1'b0);
    send_macropixel(8'd0,   8'd0,   8'd255, 8'd255, 1'b1);
    send_macropixel(8'd85,  8'd170, 8'd170, 8'd85,  1'b0);
    send_macropixel(8'd170, 8'd85,  8'd85,  8'd170, 1'b1);
  endtask

  initial begin
    int phase;
    int sent;
    int line_len;
    int k;
    logic sd;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // corners under both coefficient sets
    write_standard(1'b0);
    run_corners();
    settle_block();
    write_standard(1'b1);
    run_corners();
    settle_block();

    // random lines; each phase sets the standard while idle
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      sd = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
      write_standard(sd);
      steady = (phase == 1) || ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < BEATS_PER_PHASE) begin
        line_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
        for (k = 0; k < line_len; k++) begin
          send_macropixel(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                          k == line_len - 1);
          sent++;
        end
      end
      settle_block();
    end

    // settle_block above already drained; a little extra for stray pixels
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS uyvy_to_bgr_pixel_converter_top");
    end else begin
      $display("FAIL uyvy_to_bgr_pixel_converter_top");
    end
    $finish;
  end

endmodule

@@ uyvy_to_bgr_pixel_converter_top.f @@
src/uyv_pkg.sv
src/uyv_pair.sv
src/uyv_convert.sv
src/uyvy_to_bgr_pixel_converter_top.sv
src/uyv_checker.sv
tb/sv/bgr_pixel_checker.sv
tb/sv/uyvy_to_bgr_pixel_converter_top_test.sv
